[hw/rtl/lfu_pkg.sv]
// lfu_pkg: shared types and constants for the lfu key-value cache
// used by lfu_cell, lfu_search and lfu_key_value_cache

package lfu_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CapW = 5;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StUpdate,
    StOut
  } state_e;

  typedef enum logic [1:0] {
    OpNone,
    OpHit,
    OpEvict,
    OpInsert
  } op_e;

endpackage

[hw/rtl/lfu_cell.sv]
// lfu_cell: one cache entry with key, value, use count and recency rank
// depends on lfu_pkg

module lfu_cell #(
  parameter int unsigned CountBits = 16,
  parameter int unsigned RankBits  = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lfu_pkg::KeyW-1:0]  key_i,
  input  logic [lfu_pkg::ValW-1:0]  value_i,
  input  lfu_pkg::op_e              op_i,
  input  logic                      sel_i,
  input  logic                      owr_i,
  input  logic [RankBits-1:0]       sel_rank_i,
  output logic                      valid_o,
  output logic                      match_o,
  output logic [lfu_pkg::ValW-1:0]  value_o,
  output logic [CountBits-1:0]      count_o,
  output logic [RankBits-1:0]       rank_o
);
  import lfu_pkg::*;

  logic                 valid_q, valid_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic [ValW-1:0]      value_q, value_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [RankBits-1:0]  rank_q, rank_d;

  assign valid_o = valid_q;
  assign match_o = valid_q && (key_q == key_i);
  assign value_o = value_q;
  assign count_o = count_q;
  assign rank_o  = rank_q;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    count_d = count_q;
    rank_d  = rank_q;
    case (op_i)
      OpHit, OpEvict: begin
        if (sel_i) begin
          rank_d = '0;
          if (op_i == OpHit) begin
            if (count_q != {CountBits{1'b1}}) count_d = count_q + 1'b1;
            if (owr_i) value_d = value_i;
          end else begin
            key_d   = key_i;
            value_d = value_i;
            count_d = CountBits'(1);
          end
        end else if (valid_q && rank_q < sel_rank_i) begin
          rank_d = rank_q + 1'b1;
        end
      end
      OpInsert: begin
        if (sel_i) begin
          valid_d = 1'b1;
          key_d   = key_i;
          value_d = value_i;
          count_d = CountBits'(1);
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    count_q <= count_d;
    rank_q  <= rank_d;
  end

endmodule

[hw/rtl/lfu_search.sv]
// lfu_search: victim search stage, folds one cell per step into a running best
// depends on lfu_pkg

module lfu_search #(
  parameter int unsigned CountBits = 16,
  parameter int unsigned RankBits  = 4,
  parameter int unsigned IdxBits   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 step_i,
  input  logic [IdxBits-1:0]   idx_i,
  input  logic                 valid_i,
  input  logic [CountBits-1:0] count_i,
  input  logic [RankBits-1:0]  rank_i,
  output logic [IdxBits-1:0]   best_o
);
  import lfu_pkg::*;

  logic                 found_q, found_d;
  logic [IdxBits-1:0]   best_q, best_d;
  logic [CountBits-1:0] bcnt_q, bcnt_d;
  logic [RankBits-1:0]  brank_q, brank_d;
  logic                 better;

  assign better = valid_i && (!found_q || count_i < bcnt_q ||
                  (count_i == bcnt_q && rank_i > brank_q));
  assign best_o = best_q;

  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    bcnt_d  = bcnt_q;
    brank_d = brank_q;
    if (start_i) begin
      found_d = 1'b0;
      best_d  = '0;
    end else if (step_i && better) begin
      found_d = 1'b1;
      best_d  = idx_i;
      bcnt_d  = count_i;
      brank_d = rank_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      best_q  <= '0;
    end else begin
      found_q <= found_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcnt_q  <= bcnt_d;
    brank_q <= brank_d;
  end

endmodule

[hw/rtl/lfu_key_value_cache.sv]
// lfu_key_value_cache: top level, row of entry cells plus victim search
// depends on lfu_pkg, lfu_cell, lfu_search
//
// Key-value cache with least-frequently-used replacement and least-recently-
// used tie-break. Each entry is a cell holding key, value, saturating use
// count and recency rank, and all cells compare the key in parallel. A
// request is accepted in the idle state and matched in the search state. A
// put miss with the store at its configured capacity then runs the victim
// search, one cell a cycle through the search stage. After that come an
// update state and an output state that moves the result into the output
// register, and the result is valid from the cycle after. The next request
// is accepted while a result waits in the output register. A request whose
// result is ready waits in the output state until the output register is
// free, and the input stalls meanwhile.

module lfu_key_value_cache #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lfu_pkg::CapW-1:0]  cfg_data_i,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind_i,
  input  logic [lfu_pkg::KeyW-1:0]  key_i,
  input  logic [lfu_pkg::ValW-1:0]  value_i,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit_o,
  output logic [lfu_pkg::ValW-1:0]  read_value_o
);
  import lfu_pkg::*;

  localparam int unsigned IdxBits  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RankBits = IdxBits;
  localparam int unsigned FillBits = $clog2(ENTRIES + 1);

  state_e state_q, state_d;
  logic [CapW-1:0]     cap_q;
  logic [FillBits-1:0] fill_q, fill_d;
  logic                kind_q;
  logic [KeyW-1:0]     key_q;
  logic [ValW-1:0]     val_q;
  logic                hit_q, hit_d;
  logic [ValW-1:0]     rd_q, rd_d;
  logic [IdxBits-1:0]  slot_q, slot_d;
  logic                scan_q, scan_d;
  logic [IdxBits-1:0]  sidx_q, sidx_d;
  op_e                 op_q, op_d;
  logic                ovld_q, ovld_d;
  logic                ohit_q, ohit_d;
  logic [ValW-1:0]     ord_q, ord_d;

  logic [ENTRIES-1:0]  cvalid, cmatch, csel;
  logic [ValW-1:0]     cval   [ENTRIES];
  logic [COUNT_BITS-1:0] ccnt [ENTRIES];
  logic [RankBits-1:0] crank  [ENTRIES];
  logic [RankBits-1:0] sel_rank;
  logic [IdxBits-1:0]  match_idx, free_idx, best, upd_slot;
  logic                any_match;
  logic [CapW-1:0]     cap_eff;
  logic                accept, start;
  op_e                 cell_op;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_q != StIdle);
  assign out_valid = ovld_q;
  assign hit_o     = ohit_q;
  assign read_value_o = ord_q;
  assign cap_eff = (32'(cap_q) > ENTRIES) ? CapW'(ENTRIES) : cap_q;

  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (cmatch[j]) match_idx = IdxBits'(j);
      if (!cvalid[j]) free_idx = IdxBits'(j);
    end
  end
  assign any_match = |cmatch;
  // an eviction writes the slot that the search settled on
  assign upd_slot  = (op_q == OpEvict) ? best : slot_q;
  assign sel_rank  = crank[upd_slot];
  assign cell_op   = (state_q == StUpdate) ? op_q : OpNone;
  assign start     = (state_q == StSearch) && !scan_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign csel[g] = (upd_slot == IdxBits'(g));
    lfu_cell #(.CountBits(COUNT_BITS), .RankBits(RankBits)) u_cell (
      .clk_i, .rst_ni,
      .key_i(key_q), .value_i(val_q), .op_i(cell_op), .sel_i(csel[g]),
      .owr_i(kind_q), .sel_rank_i(sel_rank),
      .valid_o(cvalid[g]), .match_o(cmatch[g]), .value_o(cval[g]),
      .count_o(ccnt[g]), .rank_o(crank[g])
    );
  end

  lfu_search #(.CountBits(COUNT_BITS), .RankBits(RankBits), .IdxBits(IdxBits)) u_search (
    .clk_i, .rst_ni, .start_i(start), .step_i(scan_q), .idx_i(sidx_q),
    .valid_i(cvalid[sidx_q]), .count_i(ccnt[sidx_q]), .rank_i(crank[sidx_q]),
    .best_o(best)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (accept) state_d = StSearch;
      StSearch: if (!scan_d) state_d = StUpdate;
      StUpdate: state_d = StOut;
      StOut:    if (!ovld_q || !out_stall) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // datapath control
  always_comb begin
    hit_d  = hit_q;
    rd_d   = rd_q;
    slot_d = slot_q;
    scan_d = scan_q;
    sidx_d = sidx_q;
    op_d   = op_q;
    fill_d = fill_q;
    ovld_d = ovld_q;
    ohit_d = ohit_q;
    ord_d  = ord_q;
    if (ovld_q && !out_stall) ovld_d = 1'b0;
    case (state_q)
      StIdle: begin
        op_d   = OpNone;
        scan_d = 1'b0;
      end
      StSearch: begin
        if (!scan_q) begin
          hit_d  = any_match;
          rd_d   = (any_match && !kind_q) ? cval[match_idx] : '0;
          slot_d = match_idx;
          op_d   = OpNone;
          if (any_match) begin
            if (!kind_q || cap_eff != '0) op_d = OpHit;
          end else if (kind_q && cap_eff != '0) begin
            if (32'(fill_q) >= 32'(cap_eff) && fill_q != '0) begin
              op_d   = OpEvict;
              scan_d = 1'b1;
              sidx_d = '0;
            end else begin
              op_d   = OpInsert;
              slot_d = free_idx;
              fill_d = fill_q + 1'b1;
            end
          end
        end else begin
          if (sidx_q == IdxBits'(ENTRIES - 1)) scan_d = 1'b0;
          else sidx_d = sidx_q + 1'b1;
        end
      end
      StOut: begin
        if (!ovld_q || !out_stall) begin
          ovld_d = 1'b1;
          ohit_d = hit_q;
          ord_d  = rd_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q   <= CapW'(16);
      fill_q  <= '0;
      scan_q  <= 1'b0;
      sidx_q  <= '0;
      op_q    <= OpNone;
      slot_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) cap_q <= cfg_data_i;
      state_q <= state_d;
      fill_q  <= fill_d;
      scan_q  <= scan_d;
      sidx_q  <= sidx_d;
      op_q    <= op_d;
      slot_q  <= slot_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      key_q  <= key_i;
      val_q  <= value_i;
    end
    hit_q  <= hit_d;
    rd_q   <= rd_d;
    ohit_q <= ohit_d;
    ord_q  <= ord_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillBits'(ENTRIES)) else $error("fill count above entries");
  a_valid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> ($countones(cvalid) == int'(fill_q)))
    else $error("valid bits disagree with fill count");
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmatch)) else $error("key stored twice");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule
